// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define FB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define FB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/fbdr_pkg.sv
// Shared widths and defaults for the flat-bottom distance restraint.
`default_nettype none
package fbdr_pkg;
    localparam int FRAC_BITS_DEF       = 16;
    localparam int ATOM_INDEX_BITS_DEF = 16;
    localparam int COORD_W  = 32;
    localparam int PRM_W    = 31;
    localparam int ENERGY_W = 63;
    localparam int MAG_W    = 33;
    localparam int PROD_W   = 2 * MAG_W;
    localparam int ACC_W    = 97;
    localparam int PUSH_W   = 32;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
    localparam logic [PUSH_W-1:0]   POS_LIM    = 32'h7FFF_FFFF;
    localparam logic [PUSH_W-1:0]   NEG_LIM    = 32'h8000_0000;
endpackage
`default_nettype wire

// File: rtl/fbdr_mul.sv
// Shared unsigned multiplier with registered product.
`default_nettype none
module fbdr_mul
(
    input  wire logic                        clk,
    input  wire logic [fbdr_pkg::MAG_W-1:0]  a,
    input  wire logic [fbdr_pkg::MAG_W-1:0]  b,
    output logic      [fbdr_pkg::PROD_W-1:0] prod
);
    logic [fbdr_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= fbdr_pkg::PROD_W'(a) * fbdr_pkg::PROD_W'(b);
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire

// File: rtl/flat_bottom_distance_restraint.sv
// Flat-bottom harmonic distance restraint: energy and push vector per spring.
// Each word: squares summed, a 33-step square root, the energy terms, then per
// axis a multiply and, unless the push clips, a 32-step divide; no axes when the
// atoms coincide. One word at a time; the shared multiplier, the root step and
// the divide step set the rate. Reset clears the energy sum and all handshakes.
`default_nettype none
module flat_bottom_distance_restraint
#(
    parameter int FRAC_BITS       = fbdr_pkg::FRAC_BITS_DEF,
    parameter int ATOM_INDEX_BITS = fbdr_pkg::ATOM_INDEX_BITS_DEF,
    localparam int IB       = ATOM_INDEX_BITS,
    localparam int IN_BITS  = 6 * fbdr_pkg::COORD_W + 3 * fbdr_pkg::PRM_W + 2 * IB,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 2 * IB + 3 * fbdr_pkg::PUSH_W + 2 * fbdr_pkg::ENERGY_W,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, rest_length,
    // tolerance, weight, atom_first, atom_second, zero pad
    input  wire logic [IN_W-1:0] s_tdata,
    // clear_energy
    input  wire logic [0:0]      s_tuser,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    // out_atom_first, out_atom_second, push_x, push_y, push_z, term_energy,
    // energy_total, zero pad
    output logic [OUT_W-1:0]     m_tdata,
    // zero_distance, saturated
    output logic [1:0]           m_tuser
);
    localparam int CW     = fbdr_pkg::COORD_W;
    localparam int PW     = fbdr_pkg::PRM_W;
    localparam int MW     = fbdr_pkg::MAG_W;
    localparam int EW     = fbdr_pkg::ENERGY_W;
    localparam int AW     = fbdr_pkg::ACC_W;
    localparam int OFF_LEN = 6 * CW;
    localparam int OFF_TOL = OFF_LEN + PW;
    localparam int OFF_WT  = OFF_TOL + PW;
    localparam int OFF_AF  = OFF_WT + PW;
    localparam int OFF_AS  = OFF_AF + IB;
    localparam int DW     = MW + FRAC_BITS;
    localparam int TE_SH  = 2 * FRAC_BITS + 1;

    // One-hot sequencer.
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SQ   = 9'b000000010,
        S_ROOT = 9'b000000100,
        S_EXC  = 9'b000001000,
        S_WE   = 9'b000010000,
        S_TE   = 9'b000100000,
        S_NUM  = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [1:0]    axis_reg, axis_next;
    logic [EW-1:0] energy_reg, energy_next;
    logic          ovalid_reg, ovalid_next;

    // Working registers for the item in flight.
    logic [MW-1:0] smag_reg [3];
    logic [2:0]    sneg_reg;
    logic [PW-1:0] w_reg, len_reg, tol_reg;
    logic [IB-1:0] af_reg, as_reg;
    logic          clr_reg;
    logic [AW-1:0] acc_reg, acc_next;
    logic [fbdr_pkg::PROD_W-1:0] rad_reg, rad_next;
    logic [MW-1:0] root_reg, root_next;
    logic [MW+1:0] srem_reg, srem_next;
    logic [MW-1:0] emag_reg, emag_next;
    logic          eneg_reg, eneg_next;
    logic          zero_reg, zero_next;
    logic [63:0]   we_reg, we_next;
    logic [EW-1:0] term_reg, term_next, total_reg, total_next;
    logic          sat_reg, sat_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [31:0]   nlo_reg, nlo_next;
    logic [31:0]   q_reg, q_next;
    logic [31:0]   push_reg [3];
    logic [31:0]   push_val;
    logic          push_wr;

    // Output register.
    logic [OUT_BITS-1:0] odata_reg;
    logic [1:0]          ouser_reg;

    logic [MW-1:0] mul_a, mul_b;
    logic [fbdr_pkg::PROD_W-1:0] prod;

    // Separation vector at capture.
    logic [MW-1:0] in_diff [3];
    logic [MW-1:0] in_mag  [3];

    logic accept;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    fbdr_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            in_diff[k] = {s_tdata[(k + 3) * CW + CW - 1], s_tdata[(k + 3) * CW +: CW]}
                       - {s_tdata[k * CW + CW - 1], s_tdata[k * CW +: CW]};
            in_mag[k]  = in_diff[k][MW-1] ? (~in_diff[k] + MW'(1)) : in_diff[k];
        end
    end

    // Operand select for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ:
            begin
                if (cnt_reg < 6'd3)
                begin
                    mul_a = smag_reg[cnt_reg[1:0]];
                    mul_b = smag_reg[cnt_reg[1:0]];
                end
            end
            S_WE:
            begin
                mul_a = MW'(w_reg);
                mul_b = emag_reg;
            end
            S_TE:
            begin
                mul_a = (cnt_reg == 6'd0) ? MW'(we_reg[31:0]) : MW'(we_reg[63:32]);
                mul_b = emag_reg;
            end
            S_NUM:
            begin
                mul_a = (cnt_reg == 6'd0) ? MW'(we_reg[31:0]) : MW'(we_reg[63:32]);
                mul_b = smag_reg[axis_reg];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Saturate and sign one push component.
    function automatic logic [32:0] push_of(input logic big, input logic [31:0] q,
                                            input logic neg);
        logic [31:0] lim;
        logic [31:0] mag;
        logic        sat;
        lim = neg ? fbdr_pkg::NEG_LIM : fbdr_pkg::POS_LIM;
        sat = big || (q > lim);
        mag = sat ? lim : q;
        return {sat, neg ? (~mag + 32'd1) : mag};
    endfunction

    logic [36:0]     rt_t, rt_trial;
    logic [AW-1:0]   wide_sum;
    logic [AW-1:0]   te_sh;
    logic            term_sat;
    logic [EW-1:0]   term_val, base;
    logic [EW:0]     sum64;
    logic [MW:0]     u;
    logic [MW-1:0]   umag;
    logic [DW-1:0]   d_full;
    logic [DW:0]     dv_t;
    logic            dv_ge;
    logic [32:0]     pres;
    logic            pneg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        axis_next   = axis_reg;
        energy_next = energy_reg;
        ovalid_next = ovalid_reg;
        acc_next    = acc_reg;
        rad_next    = rad_reg;
        root_next   = root_reg;
        srem_next   = srem_reg;
        emag_next   = emag_reg;
        eneg_next   = eneg_reg;
        zero_next   = zero_reg;
        we_next     = we_reg;
        term_next   = term_reg;
        total_next  = total_reg;
        sat_next    = sat_reg;
        rem_next    = rem_reg;
        nlo_next    = nlo_reg;
        q_next      = q_reg;
        push_val    = '0;
        push_wr     = 1'b0;

        rt_t     = {srem_reg, rad_reg[fbdr_pkg::PROD_W-1 -: 2]};
        rt_trial = {2'b00, root_reg, 2'b01};
        wide_sum = acc_reg + (AW'(prod) << 32);
        te_sh    = wide_sum >> TE_SH;
        term_sat = |te_sh[AW-1:EW];
        term_val = term_sat ? fbdr_pkg::ENERGY_MAX : te_sh[EW-1:0];
        base     = clr_reg ? '0 : energy_reg;
        sum64    = {1'b0, base} + {1'b0, term_val};
        u        = {1'b0, root_reg} - (MW + 1)'(len_reg);
        umag     = u[MW] ? (~u[MW-1:0] + MW'(1)) : u[MW-1:0];
        d_full   = DW'(root_reg) << FRAC_BITS;
        dv_t     = {rem_reg, nlo_reg[31]};
        dv_ge    = dv_t >= {1'b0, d_full};
        pneg     = eneg_reg ^ sneg_reg[axis_reg];
        pres     = '0;

        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SQ;
                    cnt_next   = '0;
                end
            end
            S_SQ:
            begin
                // Accumulate the three squares as the products come out.
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    acc_next = AW'(prod);
                end
                else if (cnt_reg == 6'd2)
                begin
                    acc_next = acc_reg + AW'(prod);
                end
                else if (cnt_reg == 6'd3)
                begin
                    rad_next   = fbdr_pkg::PROD_W'(acc_reg + AW'(prod));
                    root_next  = '0;
                    srem_next  = '0;
                    cnt_next   = '0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                // One result bit per cycle, two radicand bits in.
                rad_next = rad_reg << 2;
                if (rt_t >= rt_trial)
                begin
                    srem_next = (MW + 2)'(rt_t - rt_trial);
                    root_next = {root_reg[MW-2:0], 1'b1};
                end
                else
                begin
                    srem_next = rt_t[MW+1:0];
                    root_next = {root_reg[MW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(MW - 1))
                begin
                    state_next = S_EXC;
                end
            end
            S_EXC:
            begin
                eneg_next  = u[MW];
                emag_next  = (umag > MW'(tol_reg)) ? (umag - MW'(tol_reg)) : '0;
                zero_next  = (root_reg == '0);
                cnt_next   = '0;
                state_next = S_WE;
            end
            S_WE:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    we_next    = prod[63:0];
                    cnt_next   = '0;
                    state_next = S_TE;
                end
            end
            S_TE:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    acc_next = AW'(prod);
                end
                else if (cnt_reg == 6'd2)
                begin
                    term_next   = term_val;
                    total_next  = sum64[EW] ? fbdr_pkg::ENERGY_MAX : sum64[EW-1:0];
                    energy_next = total_next;
                    sat_next    = term_sat || sum64[EW];
                    cnt_next    = '0;
                    axis_next   = '0;
                    state_next  = zero_reg ? S_DONE : S_NUM;
                end
            end
            S_NUM:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    acc_next = AW'(prod);
                end
                else if (cnt_reg == 6'd2)
                begin
                    cnt_next = '0;
                    if (wide_sum[AW-1:32] >= (AW - 32)'(d_full))
                    begin
                        // Quotient cannot fit: clip without dividing.
                        pres     = push_of(1'b1, '0, pneg);
                        push_val = pres[31:0];
                        push_wr  = 1'b1;
                        sat_next = 1'b1;
                        if (axis_reg == 2'd2)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            axis_next = axis_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        rem_next   = wide_sum[32 +: DW];
                        nlo_next   = wide_sum[31:0];
                        q_next     = '0;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                rem_next = dv_ge ? DW'(dv_t - {1'b0, d_full}) : dv_t[DW-1:0];
                nlo_next = nlo_reg << 1;
                q_next   = {q_reg[30:0], dv_ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    pres     = push_of(1'b0, q_next, pneg);
                    push_val = pres[31:0];
                    push_wr  = 1'b1;
                    sat_next = sat_reg || pres[32];
                    cnt_next = '0;
                    if (axis_reg == 2'd2)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_NUM;
                    end
                end
            end
            S_DONE:
            begin
                // Hand off once the output register is free.
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            axis_reg   <= '0;
            energy_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            axis_reg   <= axis_next;
            energy_reg <= energy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < 3; k++)
            begin
                smag_reg[k] <= in_mag[k];
                sneg_reg[k] <= in_diff[k][MW-1];
            end
            len_reg  <= s_tdata[OFF_LEN +: PW];
            tol_reg  <= s_tdata[OFF_TOL +: PW];
            w_reg    <= s_tdata[OFF_WT +: PW];
            af_reg   <= s_tdata[OFF_AF +: IB];
            as_reg   <= s_tdata[OFF_AS +: IB];
            clr_reg  <= s_tuser[0];
            push_reg[0] <= '0;
            push_reg[1] <= '0;
            push_reg[2] <= '0;
        end
        else if (push_wr)
        begin
            push_reg[axis_reg] <= push_val;
        end
        acc_reg   <= acc_next;
        rad_reg   <= rad_next;
        root_reg  <= root_next;
        srem_reg  <= srem_next;
        emag_reg  <= emag_next;
        eneg_reg  <= eneg_next;
        zero_reg  <= zero_next;
        we_reg    <= we_next;
        term_reg  <= term_next;
        total_reg <= total_next;
        sat_reg   <= sat_next;
        rem_reg   <= rem_next;
        nlo_reg   <= nlo_next;
        q_reg     <= q_next;
        if (state_reg == S_DONE && (!ovalid_reg || m_tready))
        begin
            odata_reg <= {total_reg, term_reg, push_reg[2], push_reg[1], push_reg[0],
                          as_reg, af_reg};
            ouser_reg <= {sat_reg, zero_reg};
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = OUT_W'(odata_reg);
    assign m_tuser  = ouser_reg;
endmodule
`default_nettype wire

// File: rtl/fbdr_checker.sv
// Port-level checks for the distance restraint, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module fbdr_checker
#(
    parameter int ATOM_INDEX_BITS = fbdr_pkg::ATOM_INDEX_BITS_DEF,
    localparam int IB       = ATOM_INDEX_BITS,
    localparam int IN_BITS  = 6 * fbdr_pkg::COORD_W + 3 * fbdr_pkg::PRM_W + 2 * IB,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 2 * IB + 3 * fbdr_pkg::PUSH_W + 2 * fbdr_pkg::ENERGY_W,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8,
    localparam int OFF_PUSH = 2 * IB,
    localparam int OFF_TERM = OFF_PUSH + 3 * fbdr_pkg::PUSH_W,
    localparam int OFF_TOT  = OFF_TERM + fbdr_pkg::ENERGY_W
)
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic [IN_W-1:0]  s_tdata,
    input wire logic [0:0]       s_tuser,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic [1:0]       m_tuser
);
    logic unused_in;
    assign unused_in = ^{s_tdata, s_tuser};

    `FB_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output word changed")

    `FB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready,
        !s_tready, "input taken again while a word is in work")

    `FB_ASSERT(a_zero_push, clk, rst_n,
        !(m_tvalid && m_tuser[0]) || (m_tdata[OFF_PUSH +: 3 * fbdr_pkg::PUSH_W] == '0),
        "push vector nonzero for coinciding atoms")

    `FB_ASSERT(a_total_covers_term, clk, rst_n,
        !m_tvalid || (m_tdata[OFF_TERM +: fbdr_pkg::ENERGY_W]
                      <= m_tdata[OFF_TOT +: fbdr_pkg::ENERGY_W]),
        "energy total below this spring's term")
endmodule

bind flat_bottom_distance_restraint fbdr_checker
#(
    .ATOM_INDEX_BITS (ATOM_INDEX_BITS)
)
u_fbdr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// File: bench/flat_bottom_distance_restraint_tb.sv
// Testbench for the flat-bottom distance restraint: directed and random springs.
`timescale 1ns / 1ps
module flat_bottom_distance_restraint_tb;
    localparam int IN_W       = 320;
    localparam int OUT_W      = 256;
    localparam int FRAC       = fbdr_pkg::FRAC_BITS_DEF;
    localparam int IDLE_LIMIT = 20000;  // long hold-off plus spring latencies
    localparam int HOLD_LEN   = 1500;
    localparam int TAIL_WAIT  = 400;    // margin of worst-case spring latencies
    localparam logic [30:0] PRM_MAX = 31'h7FFF_FFFF;

    // One spring as it goes into the block.
    typedef struct packed {
        logic clear_energy;
        logic [15:0] atom_second;
        logic [15:0] atom_first;
        logic [30:0] weight;
        logic [30:0] tolerance;
        logic [30:0] rest_length;
        logic signed [31:0] second_z;
        logic signed [31:0] second_y;
        logic signed [31:0] second_x;
        logic signed [31:0] first_z;
        logic signed [31:0] first_y;
        logic signed [31:0] first_x;
    } spring_t;

    // One result word as it leaves the block.
    typedef struct packed {
        logic saturated;
        logic zero_distance;
        logic [fbdr_pkg::ENERGY_W-1:0] energy_total;
        logic [fbdr_pkg::ENERGY_W-1:0] term_energy;
        logic [31:0] push_z;
        logic [31:0] push_y;
        logic [31:0] push_x;
        logic [15:0] out_atom_second;
        logic [15:0] out_atom_first;
    } force_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic [0:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0] m_tuser;

    flat_bottom_distance_restraint i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Predicted energy sum and the queue of forces still owed by the block.
    logic [fbdr_pkg::ENERGY_W-1:0] energy_acc;
    force_t pending_forces[$];
    int error_count = 0;
    int burst_left;
    int stall_pct;
    int hold_req;
    int hold_seen;
    int hold_cnt;
    int idle_cycles = 0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Work out the force word for one spring and advance the energy sum.
    function automatic force_t predict_force(spring_t sp);
        logic signed [33:0] sep[3];
        logic [33:0] sep_mag[3];
        logic [69:0] dist_sq;
        logic [34:0] d_len;
        logic [34:0] trial;
        logic signed [36:0] dev;
        logic [35:0] dev_mag;
        logic [35:0] excess;
        logic excess_neg;
        logic axis_neg;
        logic [127:0] wide;
        logic [127:0] quo;
        logic [63:0] sum;
        logic [31:0] lim;
        logic [31:0] mag;
        logic [31:0] push[3];
        force_t r;
        sep[0] = $signed({sp.second_x[31], sp.second_x}) - $signed({sp.first_x[31], sp.first_x});
        sep[1] = $signed({sp.second_y[31], sp.second_y}) - $signed({sp.first_y[31], sp.first_y});
        sep[2] = $signed({sp.second_z[31], sp.second_z}) - $signed({sp.first_z[31], sp.first_z});
        for (int i = 0; i < 3; i++)
            sep_mag[i] = sep[i] < 0 ? -sep[i] : sep[i];
        dist_sq = 70'(sep_mag[0]) * 70'(sep_mag[0]) + 70'(sep_mag[1]) * 70'(sep_mag[1])
                + 70'(sep_mag[2]) * 70'(sep_mag[2]);
        // exact integer root, one bit at a time from the top
        d_len = '0;
        for (int b = 34; b >= 0; b--)
        begin
            trial = d_len | (35'd1 << b);
            if (70'(trial) * 70'(trial) <= dist_sq)
                d_len = trial;
        end
        dev = $signed({2'b00, d_len}) - $signed({6'b0, sp.rest_length});
        dev_mag = dev < 0 ? 36'(-dev) : 36'(dev);
        excess = dev_mag > 36'(sp.tolerance) ? dev_mag - 36'(sp.tolerance) : '0;
        excess_neg = dev < 0;
        r = '0;
        wide = (128'(excess) * 128'(excess) * 128'(sp.weight)) >> (2 * FRAC + 1);
        if (wide > 128'(fbdr_pkg::ENERGY_MAX))
        begin
            r.term_energy = fbdr_pkg::ENERGY_MAX;
            r.saturated = 1'b1;
        end
        else
            r.term_energy = wide[fbdr_pkg::ENERGY_W-1:0];
        if (sp.clear_energy)
            energy_acc = '0;
        sum = 64'(energy_acc) + 64'(r.term_energy);
        if (sum > 64'(fbdr_pkg::ENERGY_MAX))
        begin
            sum = 64'(fbdr_pkg::ENERGY_MAX);
            r.saturated = 1'b1;
        end
        energy_acc = sum[fbdr_pkg::ENERGY_W-1:0];
        r.energy_total = energy_acc;
        r.out_atom_first = sp.atom_first;
        r.out_atom_second = sp.atom_second;
        r.zero_distance = (d_len == 0);
        for (int i = 0; i < 3; i++)
        begin
            push[i] = '0;
            if (d_len != 0)
            begin
                axis_neg = excess_neg ^ (sep[i] < 0);
                quo = (128'(sp.weight) * 128'(excess) * 128'(sep_mag[i]))
                    / (128'(d_len) << FRAC);
                lim = axis_neg ? fbdr_pkg::NEG_LIM : fbdr_pkg::POS_LIM;
                mag = quo[31:0];
                if (quo > 128'(lim))
                begin
                    mag = lim;
                    r.saturated = 1'b1;
                end
                push[i] = axis_neg ? -mag : mag;
            end
        end
        r.push_x = push[0];
        r.push_y = push[1];
        r.push_z = push[2];
        return r;
    endfunction

    // Offer one spring; hold it until accepted, then record what it owes.
    task automatic send_spring(spring_t sp);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, sp.atom_second, sp.atom_first, sp.weight, sp.tolerance,
                    sp.rest_length, sp.second_z, sp.second_y, sp.second_x,
                    sp.first_z, sp.first_y, sp.first_x};
        s_tuser <= sp.clear_energy;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_forces.push_back(predict_force(sp));
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // Random spring. Most are near-realistic geometry; some use the full
    // field ranges, some put the atoms on top of or next to each other.
    function automatic spring_t random_spring();
        spring_t sp;
        int kind;
        kind = $urandom_range(0, 99);
        sp.first_x = $urandom;
        sp.first_y = $urandom;
        sp.first_z = $urandom;
        sp.atom_first = 16'($urandom);
        sp.atom_second = 16'($urandom);
        sp.clear_energy = ($urandom_range(0, 19) == 0);
        if (kind < 70)
        begin
            sp.first_x = $signed($urandom_range(0, 200 << FRAC)) - (100 << FRAC);
            sp.first_y = $signed($urandom_range(0, 200 << FRAC)) - (100 << FRAC);
            sp.first_z = $signed($urandom_range(0, 200 << FRAC)) - (100 << FRAC);
            sp.second_x = sp.first_x + $signed($urandom_range(0, 40 << FRAC)) - (20 << FRAC);
            sp.second_y = sp.first_y + $signed($urandom_range(0, 40 << FRAC)) - (20 << FRAC);
            sp.second_z = sp.first_z + $signed($urandom_range(0, 40 << FRAC)) - (20 << FRAC);
            sp.rest_length = 31'($urandom_range(0, 25 << FRAC));
            sp.tolerance = 31'($urandom_range(0, 3 << FRAC));
            sp.weight = 31'($urandom_range(0, 50 << FRAC));
        end
        else if (kind < 85)
        begin
            sp.second_x = $urandom;
            sp.second_y = $urandom;
            sp.second_z = $urandom;
            sp.rest_length = 31'($urandom);
            sp.tolerance = ($urandom_range(0, 1) == 0) ? 31'($urandom) : 31'($urandom_range(0, 255));
            sp.weight = 31'($urandom);
        end
        else
        begin
            // coincident or a few LSBs apart
            sp.second_x = sp.first_x + $signed($urandom_range(0, 4)) - 2;
            sp.second_y = sp.first_y + $signed($urandom_range(0, 4)) - 2;
            sp.second_z = sp.first_z + $signed($urandom_range(0, 4)) - 2;
            sp.rest_length = 31'($urandom_range(0, 8 << FRAC));
            sp.tolerance = 31'($urandom_range(0, 4 << FRAC));
            sp.weight = $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 10 << FRAC));
        end
        return sp;
    endfunction

    function automatic spring_t make_spring(int ax, int ay, int az, int bx, int by, int bz,
                                            int len, int tol, int w, logic clr);
        spring_t sp;
        sp.first_x = ax;
        sp.first_y = ay;
        sp.first_z = az;
        sp.second_x = bx;
        sp.second_y = by;
        sp.second_z = bz;
        sp.rest_length = 31'(len);
        sp.tolerance = 31'(tol);
        sp.weight = 31'(w);
        sp.atom_first = 16'($urandom);
        sp.atom_second = 16'($urandom);
        sp.clear_energy = clr;
        return sp;
    endfunction

    // Hand-picked springs: each geometric case, the field extremes, saturation.
    task automatic test_directed();
        spring_t sp;
        int one;
        one = 1 << FRAC;
        // coincident atoms, with and without a rest length outside tolerance
        send_spring(make_spring(one, 2 * one, 3 * one, one, 2 * one, 3 * one,
                                5 * one, one, 2 * one, 1'b1));
        send_spring(make_spring(0, 0, 0, 0, 0, 0, one, 2 * one, 7 * one, 1'b0));
        // inside the flat bottom: no force, no energy
        send_spring(make_spring(0, 0, 0, 3 * one, 4 * one, 0, 5 * one, one, 9 * one, 1'b0));
        // stretched and compressed, one axis and all axes, negative separations
        send_spring(make_spring(0, 0, 0, 10 * one, 0, 0, 4 * one, one / 2, 3 * one, 1'b0));
        send_spring(make_spring(0, 0, 0, -one, -one, -one, 6 * one, 0, 5 * one, 1'b0));
        send_spring(make_spring(-7 * one, 3 * one, 2 * one, 5 * one, -9 * one, one,
                                2 * one, one, one, 1'b0));
        // zero weight, rest length equal to tolerance
        send_spring(make_spring(0, 0, 0, 0, 0, one, one, one, 0, 1'b0));
        send_spring(make_spring(0, 0, 0, 0, 0, 3 * one, 0, 0, 0, 1'b0));
        // one LSB apart
        send_spring(make_spring(0, 0, 0, 1, 0, 0, 0, 0, PRM_MAX, 1'b0));
        // extreme corners with the largest weight: push and energy clip,
        // then the sum stays clipped until cleared
        for (int i = 0; i < 3; i++)
        begin
            sp = make_spring(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             0, 0, PRM_MAX, 1'b0);
            sp.atom_first = (i == 0) ? 16'hFFFF : 16'h0000;
            sp.atom_second = (i == 0) ? 16'h0000 : 16'hFFFF;
            send_spring(sp);
        end
        send_spring(make_spring(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000,
                                32'h7FFF_FFFF, 0, PRM_MAX, 0, one, 1'b0));
        send_spring(make_spring(0, 0, 0, 0, 2 * one, 0, PRM_MAX, PRM_MAX, PRM_MAX, 1'b0));
        send_spring(make_spring(0, 0, 0, 0, 0, 0, PRM_MAX, 0, PRM_MAX, 1'b0));
        send_spring(make_spring(0, 0, 0, 4 * one, 0, 0, one, 0, one, 1'b1));
        send_spring(make_spring(0, one, 0, 0, 0, 0, 3 * one, 0, 2 * one, 1'b0));
        go_idle();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                stall_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(10, 70);
            send_spring(random_spring());
        end
        go_idle();
    endtask

    // Receiver holds off for a long stretch while springs keep being offered.
    task automatic test_backpressure();
        hold_req++;
        for (int i = 0; i < 12; i++)
            send_spring(random_spring());
        go_idle();
    endtask

    // Sender pauses until every owed force has come back.
    task automatic drain_forces();
        go_idle();
        while (pending_forces.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall pattern, or a long hold-off when one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_cnt <= HOLD_LEN;
            m_tready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Compare each accepted force word with the oldest prediction.
    always @(posedge clk)
    begin
        force_t got;
        force_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata[253:0]};
            if (pending_forces.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, got);
                error_count++;
            end
            else
            begin
                want = pending_forces.pop_front();
                if (got.out_atom_first !== want.out_atom_first)
                    $display("%0t: out_atom_first exp %h got %h", $time,
                             want.out_atom_first, got.out_atom_first);
                if (got.out_atom_second !== want.out_atom_second)
                    $display("%0t: out_atom_second exp %h got %h", $time,
                             want.out_atom_second, got.out_atom_second);
                if (got.push_x !== want.push_x)
                    $display("%0t: push_x exp %h got %h", $time, want.push_x, got.push_x);
                if (got.push_y !== want.push_y)
                    $display("%0t: push_y exp %h got %h", $time, want.push_y, got.push_y);
                if (got.push_z !== want.push_z)
                    $display("%0t: push_z exp %h got %h", $time, want.push_z, got.push_z);
                if (got.term_energy !== want.term_energy)
                    $display("%0t: term_energy exp %h got %h", $time,
                             want.term_energy, got.term_energy);
                if (got.energy_total !== want.energy_total)
                    $display("%0t: energy_total exp %h got %h", $time,
                             want.energy_total, got.energy_total);
                if (got.zero_distance !== want.zero_distance)
                    $display("%0t: zero_distance exp %b got %b", $time,
                             want.zero_distance, got.zero_distance);
                if (got.saturated !== want.saturated)
                    $display("%0t: saturated exp %b got %b", $time,
                             want.saturated, got.saturated);
                if (got !== want)
                    error_count++;
            end
        end
    end

    // Watchdog: end the run if neither side moves a word for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        energy_acc = '0;
        burst_left = 0;
        stall_pct = 0;
        hold_req = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        drain_forces();
        test_random(300);
        test_backpressure();
        drain_forces();
        test_random(420);

        drain_forces();
        repeat (TAIL_WAIT) @(posedge clk);
        if (error_count == 0 && pending_forces.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// File: flat_bottom_distance_restraint.f
+incdir+rtl
rtl/fbdr_pkg.sv
rtl/fbdr_mul.sv
rtl/flat_bottom_distance_restraint.sv
rtl/fbdr_checker.sv
bench/flat_bottom_distance_restraint_tb.sv
